[rtl/octal_field_formatter_top_assert.svh]
// ------------------------------------------------------------------------
// octal field formatter assertion macros
// short forms for the concurrent checks on the top-level ports
// ------------------------------------------------------------------------
`ifndef OCTAL_FIELD_FORMATTER_TOP_ASSERT_SVH
`define OCTAL_FIELD_FORMATTER_TOP_ASSERT_SVH

// check that holds at every clock edge, reset included
`define OFF_ASSERT_CLK(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

// check that is switched off while reset is held
`define OFF_ASSERT_RST(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`endif

[rtl/off_pkg.sv]
// ------------------------------------------------------------------------
// off_pkg
// shared types and constants of the octal field formatter
// ------------------------------------------------------------------------
`default_nettype none

package off_pkg;

    localparam int unsigned VALUE_W     = 64;
    localparam int unsigned NUM_DIGITS  = 22;
    localparam int unsigned DIGIT_IDX_W = 5;
    localparam int unsigned LEN_W       = 5;
    localparam int unsigned CNT_W       = 6;
    localparam int unsigned QUEUE_DEPTH = 2;

    localparam logic [5:0] MAX_WIDTH     = 6'd63;
    localparam logic [5:0] MAX_PRECISION = 6'd63;

    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_SPACE = 8'h20;

    // size modes
    localparam logic [2:0] SIZE_DEFAULT = 3'd0;
    localparam logic [2:0] SIZE_SHORT   = 3'd1;
    localparam logic [2:0] SIZE_CHAR    = 3'd2;
    localparam logic [2:0] SIZE_LONG    = 3'd3;
    localparam logic [2:0] SIZE_LLONG   = 3'd4;

    // one conversion, broken into its output segments
    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic               left;
        logic               hz;
        logic [CNT_W-1:0]   pad;
        logic               pad_zero;
        logic               pfx;
        logic [CNT_W-1:0]   pz;
        logic               special;
        logic               special_zero;
        logic [LEN_W-1:0]   body_len;
    } t_cmd;

    typedef enum logic [2:0] {
        PH_IDLE      = 3'd0,
        PH_LEAD_HASH = 3'd1,
        PH_LEAD_PAD  = 3'd2,
        PH_PREFIX    = 3'd3,
        PH_PREC      = 3'd4,
        PH_BODY      = 3'd5,
        PH_TAIL_HASH = 3'd6,
        PH_TAIL_PAD  = 3'd7
    } t_phase;

endpackage

`default_nettype wire

[rtl/off_front.sv]
// ------------------------------------------------------------------------
// off_front
// accepts requests, truncates the value, counts digits and works out
// the length of every output segment
// ------------------------------------------------------------------------
`default_nettype none

module off_front (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           push,
    output logic                                full,
    input  wire logic [off_pkg::VALUE_W-1:0]    i_value,
    input  wire logic [2:0]                     i_size_mode,
    input  wire logic                           i_upper_o,
    input  wire logic                           i_alt_flag,
    input  wire logic                           i_zero_pad_flag,
    input  wire logic                           i_left_flag,
    input  wire logic [5:0]                     i_field_width,
    input  wire logic signed [6:0]              i_digit_precision,
    output logic                                o_q_push,
    output off_pkg::t_cmd                       o_q_cmd,
    input  wire logic                           i_q_full
);

    // classified request
    logic                           r_valid;
    logic [off_pkg::VALUE_W-1:0]    r_val;
    logic [off_pkg::LEN_W-1:0]      r_len;
    logic                           r_isz;
    logic [5:0]                     r_w;
    logic [5:0]                     r_p;
    logic                           r_p_none;
    logic                           r_hash;
    logic                           r_zero;
    logic                           r_left;
    logic                           r_ok;

    logic                           w_ok;
    logic [off_pkg::VALUE_W-1:0]    w_val;
    logic [off_pkg::VALUE_W+1:0]    w_val_ext;
    logic [off_pkg::LEN_W-1:0]      w_len;
    logic [5:0]                     w_w;
    logic [5:0]                     w_p;

    logic                           w_p_gt;
    logic [5:0]                     w_pz;
    logic                           w_pfx;
    logic signed [7:0]              w_w1;
    logic signed [7:0]              w_w2;
    logic signed [7:0]              w_lens;
    logic                           w_hz;
    logic [5:0]                     w_pad;
    logic                           w_special;
    logic                           w_skip;
    logic [off_pkg::LEN_W-1:0]      w_body_len;
    logic                           w_nonempty;
    logic                           w_drain;
    logic                           w_accept;

    // size truncation
    always_comb begin
        w_ok  = 1'b1;
        w_val = i_value;
        unique case (i_size_mode) inside
            off_pkg::SIZE_DEFAULT: begin
                if (!i_upper_o) begin
                    w_val = {32'd0, i_value[31:0]};
                end
            end
            off_pkg::SIZE_SHORT: w_val = {48'd0, i_value[15:0]};
            off_pkg::SIZE_CHAR:  w_val = {56'd0, i_value[7:0]};
            off_pkg::SIZE_LONG, off_pkg::SIZE_LLONG: w_val = i_value;
            default: w_ok = i_upper_o;
        endcase
    end

    // digit count from the highest non-zero octal digit
    always_comb begin
        w_val_ext = {2'b00, w_val};
        w_len     = off_pkg::LEN_W'(1);
        for (int i = 0; i < off_pkg::NUM_DIGITS; i++) begin
            if (|w_val_ext[3*i +: 3]) begin
                w_len = off_pkg::LEN_W'(i + 1);
            end
        end
    end

    assign w_w = (i_field_width > off_pkg::MAX_WIDTH) ? off_pkg::MAX_WIDTH : i_field_width;
    assign w_p = (i_digit_precision[5:0] > off_pkg::MAX_PRECISION) ?
                 off_pkg::MAX_PRECISION : i_digit_precision[5:0];

    // segment lengths from the registered request
    always_comb begin
        w_lens     = $signed({3'b000, r_len});
        w_p_gt     = !r_p_none && (r_p > 6'(r_len));
        w_pz       = w_p_gt ? (r_p - 6'(r_len)) : 6'd0;
        w_pfx      = r_hash && (!r_p_none || !r_zero) && !w_p_gt && !r_isz;
        w_w1       = $signed({2'b00, r_w}) - $signed({2'b00, w_pz})
                   - $signed({7'd0, w_pfx});
        w_hz       = r_hash && r_zero && r_p_none && (w_w1 <= w_lens) && !r_isz;
        w_w2       = w_w1 - $signed({7'd0, w_hz});
        w_pad      = (w_w2 > w_lens) ? 6'(w_w2 - w_lens) : 6'd0;
        w_special  = !r_p_none && (r_p == 6'd0) && r_isz && (r_w != 6'd0);
        w_skip     = !r_p_none && (r_p == 6'd0) && r_isz && !r_hash && (r_w == 6'd0);
        w_body_len = w_special ? off_pkg::LEN_W'(1) :
                     (w_skip ? off_pkg::LEN_W'(0) : r_len);
        w_nonempty = w_hz || w_pfx || (w_pz != 6'd0) || (w_pad != 6'd0)
                   || (w_body_len != off_pkg::LEN_W'(0));
    end

    always_comb begin
        o_q_cmd.value        = r_val;
        o_q_cmd.left         = r_left;
        o_q_cmd.hz           = w_hz;
        o_q_cmd.pad          = w_pad;
        o_q_cmd.pad_zero     = r_p_none && r_zero;
        o_q_cmd.pfx          = w_pfx;
        o_q_cmd.pz           = w_pz;
        o_q_cmd.special      = w_special;
        o_q_cmd.special_zero = r_hash;
        o_q_cmd.body_len     = w_body_len;
    end

    // items with nothing to print, or with a size mode that is not accepted, are dropped here
    assign o_q_push = r_valid && r_ok && w_nonempty && !i_q_full;
    assign w_drain  = r_valid && (!(r_ok && w_nonempty) || !i_q_full);
    assign full     = r_valid && !w_drain;
    assign w_accept = push && !full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= w_accept || (r_valid && !w_drain);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_val    <= w_val;
            r_len    <= w_len;
            r_isz    <= (w_val == '0);
            r_w      <= w_w;
            r_p      <= w_p;
            r_p_none <= i_digit_precision[6];
            r_hash   <= i_alt_flag;
            r_zero   <= i_zero_pad_flag;
            r_left   <= i_left_flag;
            r_ok     <= w_ok;
        end
    end

endmodule

`default_nettype wire

[rtl/off_cmd_queue.sv]
// ------------------------------------------------------------------------
// off_cmd_queue
// short queue of segment commands between front and back
// ------------------------------------------------------------------------
`default_nettype none

module off_cmd_queue #(
    parameter int unsigned DEPTH = off_pkg::QUEUE_DEPTH
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_push,
    input  off_pkg::t_cmd       i_cmd,
    output logic                o_full,
    input  wire logic           i_pop,
    output off_pkg::t_cmd       o_head,
    output logic                o_empty
);

    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);

    off_pkg::t_cmd  r_mem [DEPTH];
    logic [AW-1:0]  r_wr;
    logic [AW-1:0]  r_rd;
    logic [CW-1:0]  r_cnt;
    logic [AW-1:0]  n_wr;
    logic [AW-1:0]  n_rd;
    logic           w_push;
    logic           w_pop;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_head  = r_mem[r_rd];
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && !o_empty;
    assign n_wr    = (r_wr == AW'(DEPTH - 1)) ? '0 : (r_wr + AW'(1));
    assign n_rd    = (r_rd == AW'(DEPTH - 1)) ? '0 : (r_rd + AW'(1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) begin
                r_wr <= n_wr;
            end
            if (w_pop) begin
                r_rd <= n_rd;
            end
            if (w_push && !w_pop) begin
                r_cnt <= r_cnt + CW'(1);
            end else if (w_pop && !w_push) begin
                r_cnt <= r_cnt - CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

endmodule

`default_nettype wire

[rtl/off_back.sv]
// ------------------------------------------------------------------------
// off_back
// walks the segments of one command and emits one character a cycle while popped
// ------------------------------------------------------------------------
`default_nettype none

module off_back (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_q_empty,
    input  off_pkg::t_cmd       i_q_head,
    output logic                o_q_pop,
    output logic                empty,
    input  wire logic           pop,
    output logic [7:0]          o_out_char,
    output logic                o_last_char
);

    off_pkg::t_phase                r_phase;
    off_pkg::t_phase                n_phase;
    logic [off_pkg::CNT_W-1:0]      r_cnt;
    logic [off_pkg::CNT_W-1:0]      n_cnt;
    off_pkg::t_cmd                  r_cmd;
    off_pkg::t_cmd                  n_cmd;
    logic                           r_out_valid;
    logic [7:0]                     r_out_char;
    logic                           r_out_last;

    off_pkg::t_phase                w_nxt;
    logic                           w_adv;
    logic                           w_emit;
    logic [7:0]                     w_char;
    logic                           w_last;
    logic [off_pkg::CNT_W-1:0]      w_cm1;
    logic [off_pkg::VALUE_W+1:0]    w_val_ext;
    logic [2:0]                     w_digits [off_pkg::NUM_DIGITS];

    function automatic logic [off_pkg::CNT_W-1:0] f_count(
        input off_pkg::t_cmd c,
        input off_pkg::t_phase ph
    );
        logic [off_pkg::CNT_W-1:0] n;
        n = '0;
        unique case (ph)
            off_pkg::PH_IDLE:      n = '0;
            off_pkg::PH_LEAD_HASH: n = off_pkg::CNT_W'(!c.left && c.hz);
            off_pkg::PH_LEAD_PAD:  n = c.left ? '0 : c.pad;
            off_pkg::PH_PREFIX:    n = off_pkg::CNT_W'(c.pfx);
            off_pkg::PH_PREC:      n = c.pz;
            off_pkg::PH_BODY:      n = off_pkg::CNT_W'(c.body_len);
            off_pkg::PH_TAIL_HASH: n = off_pkg::CNT_W'(c.left && c.hz);
            off_pkg::PH_TAIL_PAD:  n = c.left ? c.pad : '0;
            default:               n = '0;
        endcase
        return n;
    endfunction

    // first segment after cur that has any characters
    function automatic off_pkg::t_phase f_next(
        input off_pkg::t_cmd c,
        input off_pkg::t_phase cur
    );
        off_pkg::t_phase res;
        off_pkg::t_phase ph;
        res = off_pkg::PH_IDLE;
        for (int k = 7; k >= 1; k--) begin
            ph = off_pkg::t_phase'(3'(k));
            if ((k > int'(cur)) && (f_count(c, ph) != '0)) begin
                res = ph;
            end
        end
        return res;
    endfunction

    assign w_adv = !r_out_valid || pop;
    assign w_nxt = f_next(r_cmd, r_phase);

    // next state
    always_comb begin
        n_phase = r_phase;
        n_cnt   = r_cnt;
        n_cmd   = r_cmd;
        o_q_pop = 1'b0;
        unique case (r_phase)
            off_pkg::PH_IDLE: begin
                if (!i_q_empty) begin
                    o_q_pop = 1'b1;
                    n_cmd   = i_q_head;
                    n_phase = f_next(i_q_head, off_pkg::PH_IDLE);
                    n_cnt   = f_count(i_q_head, n_phase);
                end
            end
            default: begin
                if (w_adv) begin
                    if (r_cnt == off_pkg::CNT_W'(1)) begin
                        n_phase = w_nxt;
                        n_cnt   = f_count(r_cmd, w_nxt);
                    end else begin
                        n_cnt = r_cnt - off_pkg::CNT_W'(1);
                    end
                end
            end
        endcase
    end

    // digit selection, counting down from the most significant
    always_comb begin
        w_val_ext = {2'b00, r_cmd.value};
        for (int i = 0; i < off_pkg::NUM_DIGITS; i++) begin
            w_digits[i] = w_val_ext[3*i +: 3];
        end
        w_cm1 = r_cnt - off_pkg::CNT_W'(1);
    end

    // outputs
    always_comb begin
        w_emit = (r_phase != off_pkg::PH_IDLE) && w_adv;
        w_last = (r_cnt == off_pkg::CNT_W'(1)) && (w_nxt == off_pkg::PH_IDLE);
        w_char = off_pkg::CH_ZERO;
        unique case (r_phase) inside
            off_pkg::PH_LEAD_PAD, off_pkg::PH_TAIL_PAD: begin
                w_char = r_cmd.pad_zero ? off_pkg::CH_ZERO : off_pkg::CH_SPACE;
            end
            off_pkg::PH_BODY: begin
                if (r_cmd.special) begin
                    w_char = r_cmd.special_zero ? off_pkg::CH_ZERO : off_pkg::CH_SPACE;
                end else begin
                    w_char = off_pkg::CH_ZERO
                           + {5'd0, w_digits[w_cm1[off_pkg::DIGIT_IDX_W-1:0]]};
                end
            end
            default: w_char = off_pkg::CH_ZERO;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= off_pkg::PH_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_phase <= n_phase;
            if (w_emit) begin
                r_out_valid <= 1'b1;
            end else if (pop) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cnt <= n_cnt;
        r_cmd <= n_cmd;
        if (w_emit) begin
            r_out_char <= w_char;
            r_out_last <= w_last;
        end
    end

    assign empty       = !r_out_valid;
    assign o_out_char  = r_out_char;
    assign o_last_char = r_out_last;

endmodule

`default_nettype wire

[rtl/octal_field_formatter_top.sv]
// path: front register, command queue, sequencer state, output register
// throughput: one character per cycle while the consumer pops; a conversion holds the
// sequencer until its last character, then an idle state loads the next command
// the front takes a new request every cycle while the command queue has room
// reset: synchronous, active low; clears the front stage, queue pointers, sequencer
// state and the output register; no memory to clear
// ------------------------------------------------------------------------
// octal_field_formatter_top
// printf-style octal conversion emitted as a character stream
// ------------------------------------------------------------------------
`default_nettype none

module octal_field_formatter_top #(
    parameter int unsigned QUEUE_DEPTH = off_pkg::QUEUE_DEPTH
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           push,
    output logic                                full,
    input  wire logic [off_pkg::VALUE_W-1:0]    i_value,
    input  wire logic [2:0]                     i_size_mode,
    input  wire logic                           i_upper_o,
    input  wire logic                           i_alt_flag,
    input  wire logic                           i_zero_pad_flag,
    input  wire logic                           i_left_flag,
    input  wire logic [5:0]                     i_field_width,
    input  wire logic signed [6:0]              i_digit_precision,
    output logic                                empty,
    input  wire logic                           pop,
    output logic [7:0]                          o_out_char,
    output logic                                o_last_char
);

    logic           w_q_push;
    logic           w_q_full;
    logic           w_q_pop;
    logic           w_q_empty;
    off_pkg::t_cmd  w_q_cmd;
    off_pkg::t_cmd  w_q_head;

    off_front u_front (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .push              (push),
        .full              (full),
        .i_value           (i_value),
        .i_size_mode       (i_size_mode),
        .i_upper_o         (i_upper_o),
        .i_alt_flag        (i_alt_flag),
        .i_zero_pad_flag   (i_zero_pad_flag),
        .i_left_flag       (i_left_flag),
        .i_field_width     (i_field_width),
        .i_digit_precision (i_digit_precision),
        .o_q_push          (w_q_push),
        .o_q_cmd           (w_q_cmd),
        .i_q_full          (w_q_full)
    );

    off_cmd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_q_push),
        .i_cmd   (w_q_cmd),
        .o_full  (w_q_full),
        .i_pop   (w_q_pop),
        .o_head  (w_q_head),
        .o_empty (w_q_empty)
    );

    off_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_empty   (w_q_empty),
        .i_q_head    (w_q_head),
        .o_q_pop     (w_q_pop),
        .empty       (empty),
        .pop         (pop),
        .o_out_char  (o_out_char),
        .o_last_char (o_last_char)
    );

endmodule

`default_nettype wire

[rtl/off_checker.sv]
// ------------------------------------------------------------------------
// off_checker
// port-level checks on the formatter, bound to the top level
// ------------------------------------------------------------------------
`default_nettype none

`include "octal_field_formatter_top_assert.svh"

module off_checker (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       full,
    input  wire logic       empty,
    input  wire logic       pop,
    input  wire logic [7:0] o_out_char,
    input  wire logic       o_last_char
);

    // a waiting character must not change under back-pressure
    property p_hold_stall;
        (!empty && !pop) |=> (!empty && $stable(o_out_char) && $stable(o_last_char));
    endproperty

    // only octal digits or a space ever leave the block
    property p_char_set;
        !empty |-> ((o_out_char >= 8'h30 && o_out_char <= 8'h37) || o_out_char == 8'h20);
    endproperty

    `OFF_ASSERT_RST(a_hold_stall, i_clk, i_rst_n, p_hold_stall, "result changed while stalled")

    `OFF_ASSERT_RST(a_char_set, i_clk, i_rst_n, p_char_set, "character outside octal digits")

    `OFF_ASSERT_CLK(a_rst_empty, i_clk, !i_rst_n |=> empty, "result shown right after reset")

    `OFF_ASSERT_CLK(a_rst_full, i_clk, !i_rst_n |=> !full, "input blocked right after reset")

endmodule

bind octal_field_formatter_top off_checker u_off_checker (.*);

`default_nettype wire
